// File: src/drwu_pkg.sv
// Package for the readout word unpacker: parser phases, result kinds,
// register indexes and the hit word decode function.
// No dependencies.
package drwu_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned ADDR_W     = 16;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned MAX_ADDR_REGS = 4;

	localparam logic [ADDR_W-1:0] SKIP_ADDR  = 16'h5555;
	localparam logic [WORD_W-1:0] END_WORD   = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_BOARDS_IN_USE = 3'd4;

	localparam logic [1:0] KIND_HIT     = 2'd0;
	localparam logic [1:0] KIND_END_OK  = 2'd1;
	localparam logic [1:0] KIND_END_BAD = 2'd2;

	localparam logic [1:0] MODE_0 = 2'd0;
	localparam logic [1:0] MODE_1 = 2'd1;
	localparam logic [1:0] MODE_2 = 2'd2;

	typedef enum logic [3:0] {
		PH_WAIT   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_DATA   = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] board;
		logic [6:0]  strip;
		logic [13:0] time_stamp;
		logic [11:0] charge;
		logic        pileup;
		logic        overflow;
		logic        flags_valid;
	} result_t;

	function automatic result_t decode_hit(input logic [WORD_W-1:0] d, input logic new_fmt,
		input logic [1:0] mode, input logic [ADDR_W-1:0] board);
		result_t r;
		r = '0;
		r.kind  = KIND_HIT;
		r.board = board;
		if (!new_fmt) begin
			r.strip       = d[30:24];
			r.time_stamp  = {2'b00, d[11:0]};
			r.charge      = d[23:12];
			r.pileup      = d[31];
			r.overflow    = 1'b0;
			r.flags_valid = 1'b1;
		end else begin
			r.strip       = d[31:25];
			r.pileup      = d[24];
			r.overflow    = d[23];
			r.flags_valid = 1'b1;
			case (mode)
				MODE_0: begin
					r.time_stamp = {3'b000, d[10:0]};
					r.charge     = d[22:11];
				end
				MODE_1: begin
					r.time_stamp = {2'b00, d[11:0]};
					r.charge     = {d[22:12], 1'b0};
				end
				MODE_2: begin
					r.time_stamp = d[13:0];
					r.charge     = {d[22:14], 3'b000};
				end
				default: begin
					r.time_stamp  = d[13:0];
					r.charge      = {d[24:14], 1'b0};
					r.pileup      = 1'b0;
					r.overflow    = 1'b0;
					r.flags_valid = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

endpackage

// File: src/drwu_in_if.sv
// Input channel of the readout word unpacker: valid/ready plus word fields.
// Depends on nothing.
interface drwu_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        first_word;

	modport source (output valid, output word, output first_word, input ready);
	modport sink (input valid, input word, input first_word, output ready);
endinterface

// File: src/drwu_out_if.sv
// Result channel of the readout word unpacker: valid/ready plus result fields.
// Depends on nothing.
interface drwu_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] board;
	logic [6:0]  strip;
	logic [13:0] time_stamp;
	logic [11:0] charge;
	logic        pileup;
	logic        overflow;
	logic        flags_valid;

	modport source (output valid, output kind, output board, output strip, output time_stamp,
		output charge, output pileup, output overflow, output flags_valid, input ready);
	modport sink (input valid, input kind, input board, input strip, input time_stamp,
		input charge, input pileup, input overflow, input flags_valid, output ready);
endinterface

// File: src/drwu_cfg_regs.sv
// Known board address registers and the known board lookup.
// Depends on drwu_pkg.
module drwu_cfg_regs #(
	parameter int unsigned NUM_ADDR = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [drwu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [drwu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [drwu_pkg::ADDR_W-1:0]     lookup_addr,
	output logic                            lookup_known
);
	import drwu_pkg::*;

	logic [ADDR_W-1:0]    addr_q [NUM_ADDR];
	logic [CFG_IDX_W-1:0] in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ADDR; i++) addr_q[i] <= '0;
			in_use_q <= '0;
		end else if (cfg_wr_en) begin
			for (int i = 0; i < NUM_ADDR; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) addr_q[i] <= cfg_data[ADDR_W-1:0];
			end
			if (cfg_index == CFG_BOARDS_IN_USE) in_use_q <= cfg_data[CFG_IDX_W-1:0];
		end
	end

	always_comb begin
		lookup_known = 1'b0;
		for (int i = 0; i < NUM_ADDR; i++) begin
			if (CFG_IDX_W'(i) < in_use_q && addr_q[i] == lookup_addr) lookup_known = 1'b1;
		end
		if (lookup_addr == SKIP_ADDR) lookup_known = 1'b0;
	end

endmodule

// File: src/drwu_parser.sv
// Input register, parser state machine, hit decode and result register.
// Depends on drwu_pkg, drwu_in_if and drwu_out_if.
module drwu_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	drwu_in_if.sink                     in_ch,
	drwu_out_if.source                  out_ch,
	output logic [drwu_pkg::ADDR_W-1:0] lookup_addr,
	input  logic                        lookup_known
);
	import drwu_pkg::*;

	logic              v_s1;
	logic [WORD_W-1:0] word_s1;
	logic              first_s1;

	phase_t            phase_q;
	logic [CNT_W-1:0]  declared_q;
	logic [CNT_W-1:0]  seen_q;
	logic [CNT_W-1:0]  skip_left_q;
	logic              new_fmt_q;
	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] board_q;

	logic    res_v_q;
	result_t res_q;

	logic             advance;
	phase_t           phase_cur;
	logic [CNT_W-1:0] skip_cur;
	logic [CNT_W-1:0] seen_inc;
	logic [CNT_W-1:0] cnt_w;

	assign advance      = v_s1 && (!res_v_q || out_ch.ready);
	assign in_ch.ready  = !v_s1 || advance;
	assign phase_cur    = first_s1 ? PH_WAIT : phase_q;
	assign skip_cur     = first_s1 ? '0 : skip_left_q;
	assign seen_inc     = (seen_q != CNT_MAX) ? seen_q + 1'b1 : seen_q;
	assign cnt_w        = word_s1[31:16];
	assign lookup_addr  = word_s1[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			word_s1  <= in_ch.word;
			first_s1 <= in_ch.first_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			declared_q  <= '0;
			seen_q      <= '0;
			skip_left_q <= '0;
			new_fmt_q   <= 1'b0;
			mode_q      <= '0;
			board_q     <= '0;
			res_v_q     <= 1'b0;
		end else begin
			if (advance && phase_cur == PH_DATA) res_v_q <= 1'b1;
			else if (out_ch.ready) res_v_q <= 1'b0;
			if (advance) begin
				unique case (phase_cur)
					PH_WAIT: begin
						board_q <= word_s1[ADDR_W-1:0];
						if (cnt_w != '0) begin
							declared_q <= cnt_w;
							seen_q     <= '0;
							if (lookup_known) begin
								skip_left_q <= skip_cur;
								phase_q     <= PH_HEADER;
							end else begin
								skip_left_q <= cnt_w;
								phase_q     <= PH_SKIP;
							end
						end else begin
							skip_left_q <= skip_cur;
							phase_q     <= PH_WAIT;
						end
					end
					PH_HEADER: begin
						new_fmt_q   <= (word_s1[31:30] != 2'b00);
						mode_q      <= word_s1[23:22];
						seen_q      <= seen_inc;
						skip_left_q <= skip_cur;
						phase_q     <= PH_DATA;
					end
					PH_DATA: begin
						seen_q      <= seen_inc;
						skip_left_q <= skip_cur;
						if (word_s1 == END_WORD) phase_q <= PH_WAIT;
					end
					PH_SKIP: begin
						if (skip_cur <= CNT_W'(1)) phase_q <= PH_WAIT;
						skip_left_q <= (skip_cur != '0) ? skip_cur - 1'b1 : skip_cur;
					end
					default: begin
						phase_q     <= PH_WAIT;
						skip_left_q <= skip_cur;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && phase_cur == PH_DATA) begin
			if (word_s1 == END_WORD) begin
				res_q <= '{kind: (seen_inc == declared_q) ? KIND_END_OK : KIND_END_BAD,
					board: board_q, default: '0};
			end else begin
				res_q <= decode_hit(word_s1, new_fmt_q, mode_q, board_q);
			end
		end
	end

	assign out_ch.valid       = res_v_q;
	assign out_ch.kind        = res_q.kind;
	assign out_ch.board       = res_q.board;
	assign out_ch.strip       = res_q.strip;
	assign out_ch.time_stamp  = res_q.time_stamp;
	assign out_ch.charge      = res_q.charge;
	assign out_ch.pileup      = res_q.pileup;
	assign out_ch.overflow    = res_q.overflow;
	assign out_ch.flags_valid = res_q.flags_valid;

`ifndef SYNTHESIS
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_left_q != '0)
		else $error("skip phase with no words left");
	a_header_fresh_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> seen_q == '0)
		else $error("word count not cleared at board header");
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_v_q |-> in_ch.ready)
		else $error("input stalled with empty result register");
	a_end_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.kind != KIND_HIT |-> res_q.flags_valid == 1'b0 && res_q.charge == '0)
		else $error("board end result carries hit fields");
`endif

endmodule

// File: src/detector_readout_word_unpacker_core.sv
// Readout word unpacker top level: known board registers and word parser.
// A word passes the input register and then the result register to the output.
// Throughput: one word per cycle unless out_ch stalls; parser state updates once
// per word in one register stage; the result register frees the input side.
// Reset clears parser state and configuration registers at once; no clearing pass.
module detector_readout_word_unpacker_core #(
	parameter int unsigned KNOWN_BOARDS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [drwu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [drwu_pkg::CFG_DATA_W-1:0] cfg_data,
	drwu_in_if.sink                         in_ch,
	drwu_out_if.source                      out_ch
);
	import drwu_pkg::*;

	localparam int unsigned NUM_ADDR =
		(KNOWN_BOARDS < MAX_ADDR_REGS) ? KNOWN_BOARDS : MAX_ADDR_REGS;

	logic [ADDR_W-1:0] lookup_addr;
	logic              lookup_known;

	drwu_cfg_regs #(
		.NUM_ADDR(NUM_ADDR)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.lookup_addr  (lookup_addr),
		.lookup_known (lookup_known)
	);

	drwu_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.lookup_addr  (lookup_addr),
		.lookup_known (lookup_known)
	);

endmodule
